[hw/rtl/mta_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types and constants of the mesh tangent accumulator.
// ----------------------------------------------------------------------------
package mta_pkg;

  localparam int unsigned VERTEX_COUNT = 1024;
  localparam int unsigned IDX_W        = $clog2(VERTEX_COUNT);
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned CRD_W        = 32;
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned QUO_W        = 48;
  localparam int unsigned OUT_W        = 16;
  localparam int unsigned OUT_FRAC     = 15;
  localparam int unsigned MAG_W        = 30;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned MUL_STEPS    = 8;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]        OUT_ONE = {1'b0, {(OUT_W-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_T_RA,
    ST_T_RB,
    ST_T_RC,
    ST_T_LD,
    ST_T_MUL,
    ST_T_DIV,
    ST_T_DWAIT,
    ST_T_SRD,
    ST_T_SWR,
    ST_R_RD,
    ST_R_MAG,
    ST_R_SHIFT,
    ST_R_SQ,
    ST_R_SQS,
    ST_R_SQW,
    ST_R_DIV,
    ST_R_DWAIT,
    ST_R_OUT
  } state_e;

  typedef struct packed {
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;
    logic signed [CRD_W-1:0] pos_z;
    logic signed [CRD_W-1:0] tex_u;
    logic signed [CRD_W-1:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sum_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
    vtx_t             vtx;
  } item_t;

  typedef struct packed {
    logic [63:0]      hi;
    logic [QUO_W-1:0] lo;
    logic [63:0]      den;
  } div_req_t;

endpackage
`default_nettype wire

[hw/rtl/mesh_tangent_accumulate_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_tangent_accumulate_core
// Per-vertex tangent accumulation and normalised read-back, Q16.16 in, Q1.15 out.
// ----------------------------------------------------------------------------
// A vertex write is taken in the idle state. In a triangle each component is
// resolved at once (zero numerator or saturation) or through the bit-serial
// divider; a zero determinant ends the triangle with no sum update. A read
// shifts the magnitudes, takes the square root and divides each component; a
// zero sum skips to the output. A two-word queue decouples input from the
// sequencer. After reset the sum memory is swept to zero, input held off.
module mesh_tangent_accumulate_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     func_i,
  input  wire logic [mta_pkg::IDX_W-1:0]      vertex_index_i,
  input  wire logic signed [31:0]             pos_x_i,
  input  wire logic signed [31:0]             pos_y_i,
  input  wire logic signed [31:0]             pos_z_i,
  input  wire logic signed [31:0]             tex_u_i,
  input  wire logic signed [31:0]             tex_v_i,
  input  wire logic [mta_pkg::IDX_W-1:0]      second_index_i,
  input  wire logic [mta_pkg::IDX_W-1:0]      third_index_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [mta_pkg::OUT_W-1:0]    tangent_x_o,
  output logic signed [mta_pkg::OUT_W-1:0]    tangent_y_o,
  output logic signed [mta_pkg::OUT_W-1:0]    tangent_z_o,
  output logic                                zero_length_o
);

  logic           q_valid, q_ready, clearing;
  mta_pkg::item_t q_item;

  mta_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .vertex_index_i (vertex_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .tex_u_i        (tex_u_i),
    .tex_v_i        (tex_v_i),
    .second_index_i (second_index_i),
    .third_index_i  (third_index_i),
    .clearing_i     (clearing),
    .q_valid_o      (q_valid),
    .q_ready_i      (q_ready),
    .q_item_o       (q_item)
  );

  mta_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tangent_x_o   (tangent_x_o),
    .tangent_y_o   (tangent_y_o),
    .tangent_z_o   (tangent_z_o),
    .zero_length_o (zero_length_o)
  );

  a_no_input_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !in_ready_o
  ) else $error("input taken during sum sweep");

  a_zero_flag_zero_vector: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |->
      tangent_x_o == '0 && tangent_y_o == '0 && tangent_z_o == '0
  ) else $error("zero-length result carries a non-zero vector");

  a_unit_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tangent_x_o != 16'sh8000 && tangent_y_o != 16'sh8000 &&
                    tangent_z_o != 16'sh8000
  ) else $error("normalised component outside unit range");

endmodule
`default_nettype wire

[hw/rtl/mta_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mta_front
// Accepts input words, drops unused codes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module mta_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   func_i,
  input  wire logic [mta_pkg::IDX_W-1:0]    vertex_index_i,
  input  wire logic signed [31:0]           pos_x_i,
  input  wire logic signed [31:0]           pos_y_i,
  input  wire logic signed [31:0]           pos_z_i,
  input  wire logic signed [31:0]           tex_u_i,
  input  wire logic signed [31:0]           tex_v_i,
  input  wire logic [mta_pkg::IDX_W-1:0]    second_index_i,
  input  wire logic [mta_pkg::IDX_W-1:0]    third_index_i,
  input  wire logic                         clearing_i,
  output logic                              q_valid_o,
  input  wire logic                         q_ready_i,
  output mta_pkg::item_t                    q_item_o
);

  localparam int unsigned PTR_W = $clog2(mta_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(mta_pkg::QUEUE_DEPTH + 1);

  mta_pkg::item_t    entry_q [mta_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              known, push, pop;
  mta_pkg::item_t    item;

  always_comb begin
    case (func_i)
      mta_pkg::OP_WRITE, mta_pkg::OP_TRI, mta_pkg::OP_READ: known = 1'b1;
      default:                                             known = 1'b0;
    endcase
  end

  assign item.op        = mta_pkg::op_e'(func_i);
  assign item.idx_a     = vertex_index_i;
  assign item.idx_b     = second_index_i;
  assign item.idx_c     = third_index_i;
  assign item.vtx.pos_x = pos_x_i;
  assign item.vtx.pos_y = pos_y_i;
  assign item.vtx.pos_z = pos_z_i;
  assign item.vtx.tex_u = tex_u_i;
  assign item.vtx.tex_v = tex_v_i;

  assign in_ready_o = (cnt_q != CNT_W'(mta_pkg::QUEUE_DEPTH)) && !clearing_i;
  // drop unused codes at the door
  assign push       = in_valid_i && in_ready_o && known;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mta_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mta_div
// Restoring divider, one quotient bit a cycle; high part must be below divisor.
// ----------------------------------------------------------------------------
module mta_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire mta_pkg::div_req_t         req_i,
  output logic                           done_o,
  output logic [mta_pkg::QUO_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(mta_pkg::QUO_W);

  logic [63:0]               rem_q, den_q;
  logic [mta_pkg::QUO_W-1:0] dq_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q, done_q;
  logic [64:0]               r2, diff;
  logic                      ge;

  assign r2     = {rem_q, dq_q[mta_pkg::QUO_W-1]};
  assign diff   = r2 - {1'b0, den_q};
  assign ge     = (r2 >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = dq_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= req_i.hi;
      dq_q  <= req_i.lo;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? diff[63:0] : r2[63:0];
      dq_q  <= {dq_q[mta_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(mta_pkg::QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mta_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mta_sqrt
// Integer square root, floor, one result bit a cycle.
// ----------------------------------------------------------------------------
module mta_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] val_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [63:0] n_q, r_q, bit_q, trial;
  logic        busy_q, done_q, take;

  assign trial  = r_q + bit_q;
  assign take   = (n_q >= trial);
  assign done_o = done_q;
  assign root_o = r_q[31:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= val_i;
      r_q   <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (take) begin
        n_q <= n_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == 64'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mta_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mta_back
// Sequencer owning the vertex and sum memories; runs one queued word at a time.
// ----------------------------------------------------------------------------
module mta_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             q_valid_i,
  output logic                                  q_ready_o,
  input  wire mta_pkg::item_t                   q_item_i,
  output logic                                  clearing_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [mta_pkg::OUT_W-1:0]      tangent_x_o,
  output logic signed [mta_pkg::OUT_W-1:0]      tangent_y_o,
  output logic signed [mta_pkg::OUT_W-1:0]      tangent_z_o,
  output logic                                  zero_length_o
);

  localparam int unsigned IW = mta_pkg::IDX_W;
  localparam int unsigned SW = mta_pkg::SUM_W;
  localparam int unsigned OW = mta_pkg::OUT_W;
  localparam int unsigned QW = mta_pkg::QUO_W;
  localparam int unsigned MW = mta_pkg::MAG_W;

  function automatic logic signed [31:0] sat_delta(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d > 33'sh0_7FFF_FFFF)       sat_delta = 32'sh7FFF_FFFF;
    else if (d < -33'sh0_7FFF_FFFF) sat_delta = 32'sh8000_0001;
    else                            sat_delta = d[31:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    logic signed [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s[SW] != s[SW-1]) sat_add = s[SW] ? mta_pkg::SUM_MIN : mta_pkg::SUM_MAX;
    else                  sat_add = s[SW-1:0];
  endfunction

  mta_pkg::state_e state_q, state_d;
  mta_pkg::item_t  item_q;

  // memories
  mta_pkg::vtx_t vmem [mta_pkg::VERTEX_COUNT];
  mta_pkg::sum_t smem [mta_pkg::VERTEX_COUNT];
  mta_pkg::vtx_t vrd_q;
  mta_pkg::sum_t srd_q;
  logic          vm_we, sm_we;
  logic [IW-1:0] vm_raddr, sm_raddr, sm_waddr;
  mta_pkg::sum_t sm_wdata;

  logic [IW-1:0] clr_q;

  // triangle datapath
  mta_pkg::vtx_t      p0_q, p1_q;
  logic signed [31:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [31:0] d1u_q, d1v_q, d2u_q, d2v_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p, prod_q, first_q;
  logic signed [63:0] term_q [4];
  logic signed [SW-1:0] t_q [3];
  logic [3:0]         cnt_q, cnt_m1;
  logic [1:0]         comp_q, corner_q;

  // read datapath
  logic [SW-1:0]      mag_q [3];
  logic [SW-1:0]      big_q;
  logic [2:0]         sgn_q;
  logic [61:0]        ssq_q;
  logic [31:0]        len_q;
  logic signed [OW-1:0] res_q [3];
  logic               zl_q;

  // output register
  logic               out_valid_q, zl_out_q, out_load;
  logic signed [OW-1:0] out_x_q, out_y_q, out_z_q;

  // divider, shared by triangle and read, and square root
  logic               div_start, div_done, sq_start, sq_done;
  mta_pkg::div_req_t  div_req;
  logic [QW-1:0]      div_quo;
  logic [31:0]        sq_root;

  mta_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  mta_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   ({2'b00, ssq_q}),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // tangent component under division
  logic signed [63:0] num_sel;
  logic [63:0]        n_mag, d_mag, n_hi;
  logic               t_neg, t_sat;
  logic [IW-1:0]      corner_idx;
  logic [SW-1:0]      t_quo;
  logic [SW-1:0]      mx, my, mz, mxy;
  logic [OW-1:0]      r_quo;

  assign num_sel = term_q[comp_q + 2'd1];
  assign n_mag   = num_sel[63] ? 64'(-num_sel) : 64'(num_sel);
  assign d_mag   = term_q[0][63] ? 64'(-term_q[0]) : 64'(term_q[0]);
  assign n_hi    = n_mag >> (QW - mta_pkg::FRAC_BITS);
  assign t_neg   = num_sel[63] ^ term_q[0][63];
  assign t_sat   = (n_hi >= d_mag);
  assign t_quo   = div_quo[QW-1] ? mta_pkg::SUM_MAX : SW'(div_quo);
  assign r_quo   = (div_quo[QW-1:mta_pkg::OUT_FRAC] != '0) ? mta_pkg::OUT_ONE
                                                           : div_quo[OW-1:0];
  assign cnt_m1  = cnt_q - 4'd1;

  assign mx  = srd_q.x[SW-1] ? SW'(-srd_q.x) : SW'(srd_q.x);
  assign my  = srd_q.y[SW-1] ? SW'(-srd_q.y) : SW'(srd_q.y);
  assign mz  = srd_q.z[SW-1] ? SW'(-srd_q.z) : SW'(srd_q.z);
  assign mxy = (mx > my) ? mx : my;

  always_comb begin
    case (corner_q)
      2'd0:    corner_idx = item_q.idx_a;
      2'd1:    corner_idx = item_q.idx_b;
      default: corner_idx = item_q.idx_c;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign out_load = (state_q == mta_pkg::ST_R_OUT) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mta_pkg::ST_CLEAR:
        if (clr_q == IW'(mta_pkg::VERTEX_COUNT - 1)) state_d = mta_pkg::ST_IDLE;
      mta_pkg::ST_IDLE:
        if (q_valid_i) begin
          case (q_item_i.op)
            mta_pkg::OP_TRI:  state_d = mta_pkg::ST_T_RA;
            mta_pkg::OP_READ: state_d = mta_pkg::ST_R_RD;
            default:          state_d = mta_pkg::ST_IDLE;
          endcase
        end
      mta_pkg::ST_T_RA:  state_d = mta_pkg::ST_T_RB;
      mta_pkg::ST_T_RB:  state_d = mta_pkg::ST_T_RC;
      mta_pkg::ST_T_RC:  state_d = mta_pkg::ST_T_LD;
      mta_pkg::ST_T_LD:  state_d = mta_pkg::ST_T_MUL;
      mta_pkg::ST_T_MUL:
        if (cnt_q == 4'(mta_pkg::MUL_STEPS)) state_d = mta_pkg::ST_T_DIV;
      mta_pkg::ST_T_DIV:
        if (term_q[0] == '0)                       state_d = mta_pkg::ST_IDLE;
        else if (n_mag != '0 && !t_sat)            state_d = mta_pkg::ST_T_DWAIT;
        else if (comp_q == 2'd2)                   state_d = mta_pkg::ST_T_SRD;
      mta_pkg::ST_T_DWAIT:
        if (div_done) state_d = (comp_q == 2'd2) ? mta_pkg::ST_T_SRD : mta_pkg::ST_T_DIV;
      mta_pkg::ST_T_SRD: state_d = mta_pkg::ST_T_SWR;
      mta_pkg::ST_T_SWR:
        state_d = (corner_q == 2'd2) ? mta_pkg::ST_IDLE : mta_pkg::ST_T_SRD;
      mta_pkg::ST_R_RD:  state_d = mta_pkg::ST_R_MAG;
      mta_pkg::ST_R_MAG:
        state_d = (mxy == '0 && mz == '0) ? mta_pkg::ST_R_OUT : mta_pkg::ST_R_SHIFT;
      mta_pkg::ST_R_SHIFT:
        if (big_q[SW-1:MW] == '0) state_d = mta_pkg::ST_R_SQ;
      mta_pkg::ST_R_SQ:
        if (cnt_q == 4'd3) state_d = mta_pkg::ST_R_SQS;
      mta_pkg::ST_R_SQS: state_d = mta_pkg::ST_R_SQW;
      mta_pkg::ST_R_SQW:
        if (sq_done) state_d = mta_pkg::ST_R_DIV;
      mta_pkg::ST_R_DIV: state_d = mta_pkg::ST_R_DWAIT;
      mta_pkg::ST_R_DWAIT:
        if (div_done) state_d = (comp_q == 2'd2) ? mta_pkg::ST_R_OUT : mta_pkg::ST_R_DIV;
      mta_pkg::ST_R_OUT:
        if (out_load) state_d = mta_pkg::ST_IDLE;
      default: state_d = mta_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_ready_o  = 1'b0;
    clearing_o = 1'b0;
    vm_we      = 1'b0;
    sm_we      = 1'b0;
    vm_raddr   = item_q.idx_a;
    sm_raddr   = item_q.idx_a;
    sm_waddr   = q_item_i.idx_a;
    sm_wdata   = '0;
    div_start  = 1'b0;
    div_req    = '0;
    sq_start   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      mta_pkg::ST_CLEAR: begin
        clearing_o = 1'b1;
        sm_we      = 1'b1;
        sm_waddr   = clr_q;
      end
      mta_pkg::ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i && q_item_i.op == mta_pkg::OP_WRITE) begin
          vm_we = 1'b1;
          sm_we = 1'b1;
        end
      end
      mta_pkg::ST_T_RB: vm_raddr = item_q.idx_b;
      mta_pkg::ST_T_RC: vm_raddr = item_q.idx_c;
      mta_pkg::ST_T_MUL: begin
        case (cnt_q)
          4'd0:    begin mul_a = d1u_q; mul_b = d2v_q; end
          4'd1:    begin mul_a = d2u_q; mul_b = d1v_q; end
          4'd2:    begin mul_a = d2v_q; mul_b = e1x_q; end
          4'd3:    begin mul_a = d1v_q; mul_b = e2x_q; end
          4'd4:    begin mul_a = d2v_q; mul_b = e1y_q; end
          4'd5:    begin mul_a = d1v_q; mul_b = e2y_q; end
          4'd6:    begin mul_a = d2v_q; mul_b = e1z_q; end
          4'd7:    begin mul_a = d1v_q; mul_b = e2z_q; end
          default: begin mul_a = '0;    mul_b = '0;    end
        endcase
      end
      mta_pkg::ST_T_DIV: begin
        div_req.hi  = n_hi;
        div_req.lo  = QW'(n_mag << mta_pkg::FRAC_BITS);
        div_req.den = d_mag;
        div_start   = (term_q[0] != '0) && (n_mag != '0) && !t_sat;
      end
      mta_pkg::ST_T_SRD: sm_raddr = corner_idx;
      mta_pkg::ST_T_SWR: begin
        sm_we      = 1'b1;
        sm_waddr   = corner_idx;
        sm_wdata.x = sat_add(srd_q.x, t_q[0]);
        sm_wdata.y = sat_add(srd_q.y, t_q[1]);
        sm_wdata.z = sat_add(srd_q.z, t_q[2]);
      end
      mta_pkg::ST_R_SQ: begin
        if (cnt_q != 4'd3) begin
          mul_a = {{(32-MW){1'b0}}, mag_q[cnt_q[1:0]][MW-1:0]};
          mul_b = mul_a;
        end
      end
      mta_pkg::ST_R_SQS: sq_start = 1'b1;
      mta_pkg::ST_R_DIV: begin
        div_req.hi  = '0;
        div_req.lo  = {{(QW-MW-mta_pkg::OUT_FRAC){1'b0}}, mag_q[comp_q][MW-1:0],
                       {mta_pkg::OUT_FRAC{1'b0}}};
        div_req.den = {32'd0, len_q};
        div_start   = 1'b1;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (vm_we) vmem[q_item_i.idx_a] <= q_item_i.vtx;
    if (sm_we) smem[sm_waddr] <= sm_wdata;
    vrd_q <= vmem[vm_raddr];
    srd_q <= smem[sm_raddr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      mta_pkg::ST_IDLE: if (q_valid_i) item_q <= q_item_i;
      mta_pkg::ST_T_RB: p0_q <= vrd_q;
      mta_pkg::ST_T_RC: p1_q <= vrd_q;
      mta_pkg::ST_T_LD: begin
        e1x_q <= sat_delta(p1_q.pos_x,  p0_q.pos_x);
        e1y_q <= sat_delta(p1_q.pos_y,  p0_q.pos_y);
        e1z_q <= sat_delta(p1_q.pos_z,  p0_q.pos_z);
        e2x_q <= sat_delta(vrd_q.pos_x, p0_q.pos_x);
        e2y_q <= sat_delta(vrd_q.pos_y, p0_q.pos_y);
        e2z_q <= sat_delta(vrd_q.pos_z, p0_q.pos_z);
        d1u_q <= sat_delta(p1_q.tex_u,  p0_q.tex_u);
        d1v_q <= sat_delta(p1_q.tex_v,  p0_q.tex_v);
        d2u_q <= sat_delta(vrd_q.tex_u, p0_q.tex_u);
        d2v_q <= sat_delta(vrd_q.tex_v, p0_q.tex_v);
        cnt_q <= '0;
      end
      mta_pkg::ST_T_MUL: begin
        // one product a cycle; pair them up into determinant and numerators
        prod_q <= mul_p;
        if (cnt_q != 4'd0) begin
          if (!cnt_m1[0]) first_q <= prod_q;
          else            term_q[cnt_m1[2:1]] <= first_q - prod_q;
        end
        cnt_q  <= cnt_q + 4'd1;
        comp_q <= '0;
      end
      mta_pkg::ST_T_DIV: begin
        if (n_mag == '0 || t_sat) begin
          if (n_mag == '0)  t_q[comp_q] <= '0;
          else              t_q[comp_q] <= t_neg ? SW'(-mta_pkg::SUM_MAX)
                                                 : mta_pkg::SUM_MAX;
          comp_q <= comp_q + 2'd1;
        end
        corner_q <= '0;
      end
      mta_pkg::ST_T_DWAIT: begin
        if (div_done) begin
          t_q[comp_q] <= t_neg ? SW'(-t_quo) : t_quo;
          comp_q      <= comp_q + 2'd1;
        end
      end
      mta_pkg::ST_T_SWR: corner_q <= corner_q + 2'd1;
      mta_pkg::ST_R_MAG: begin
        mag_q[0] <= mx;
        mag_q[1] <= my;
        mag_q[2] <= mz;
        big_q    <= (mz > mxy) ? mz : mxy;
        sgn_q    <= {srd_q.z[SW-1], srd_q.y[SW-1], srd_q.x[SW-1]};
        res_q[0] <= '0;
        res_q[1] <= '0;
        res_q[2] <= '0;
        zl_q     <= 1'b1;
      end
      mta_pkg::ST_R_SHIFT: begin
        // halve all three until the largest fits the square path
        if (big_q[SW-1:MW] != '0) begin
          mag_q[0] <= mag_q[0] >> 1;
          mag_q[1] <= mag_q[1] >> 1;
          mag_q[2] <= mag_q[2] >> 1;
          big_q    <= big_q >> 1;
        end
        cnt_q <= '0;
        ssq_q <= '0;
      end
      mta_pkg::ST_R_SQ: begin
        prod_q <= mul_p;
        if (cnt_q != 4'd0) ssq_q <= ssq_q + prod_q[61:0];
        cnt_q <= cnt_q + 4'd1;
      end
      mta_pkg::ST_R_SQW: begin
        if (sq_done) len_q <= (sq_root == '0) ? 32'd1 : sq_root;
        comp_q <= '0;
      end
      mta_pkg::ST_R_DWAIT: begin
        if (div_done) begin
          res_q[comp_q] <= sgn_q[comp_q] ? OW'(-r_quo) : r_quo;
          zl_q          <= 1'b0;
          comp_q        <= comp_q + 2'd1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_x_q  <= res_q[0];
      out_y_q  <= res_q[1];
      out_z_q  <= res_q[2];
      zl_out_q <= zl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mta_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mta_pkg::ST_CLEAR) clr_q <= clr_q + IW'(1);
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tangent_x_o   = out_x_q;
  assign tangent_y_o   = out_y_q;
  assign tangent_z_o   = out_z_q;
  assign zero_length_o = zl_out_q;

endmodule
`default_nettype wire

[verif/tb_mesh_tangent_accumulate_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_tangent_accumulate_core
// Self-checking bench for the tangent accumulator. A directed table covers
// reset, a unit-axis triangle, extreme coordinates, saturation, degenerate
// and repeated-corner triangles and the unused function code. A random mix of
// vertex writes, triangles over written vertices, reads and unused codes follows. Each
// read is checked against a fixed tangent in the table or a fixed-point predictor in the bench.
// ----------------------------------------------------------------------------
module tb_mesh_tangent_accumulate_core;

  localparam int          IW        = mta_pkg::IDX_W;
  localparam int          VN        = mta_pkg::VERTEX_COUNT;
  localparam int          N_RANDOM  = 1880;
  localparam int          CYC_LIMIT = 3000000;
  localparam logic [1:0]  FN_UNUSED = 2'd3;
  localparam longint      DMAX      = 64'sd2147483647;
  localparam longint      SMAX      = 64'sd140737488355327;
  localparam longint      SMIN      = -64'sd140737488355328;

  typedef struct {
    logic [1:0]        fn;
    int                ia, ib, ic;
    logic signed [31:0] px, py, pz, tu, tv;
    bit                typed;
    logic signed [15:0] ex, ey, ez;
    logic              ezl;
  } row_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic              zl;
  } tangent_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = 2'd0;
  logic [IW-1:0] vertex_index_i = '0, second_index_i = '0, third_index_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0, tex_u_i = '0, tex_v_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic zero_length_o;

  mesh_tangent_accumulate_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .vertex_index_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .tex_u_i, .tex_v_i, .second_index_i,
    .third_index_i, .out_valid_o, .out_ready_i, .tangent_x_o, .tangent_y_o,
    .tangent_z_o, .zero_length_o
  );

  always #4 clk_i = ~clk_i;

  longint   vx [VN], vy [VN], vz [VN];
  longint   vu [VN], vv [VN];
  longint   acc_x [VN], acc_y [VN], acc_z [VN];
  bit       written [VN];
  int       written_q [$];
  tangent_t tangent_q [$];
  row_t     steps [$];
  int       errors = 0;
  int       cycles = 0;
  bit       burst = 1'b0;

  function automatic void add_step(row_t r);
    steps = {steps, r};
  endfunction

  function automatic longint sat_diff(longint a, longint b);
    longint d;
    d = a - b;
    if (d > DMAX) return DMAX;
    if (d < -DMAX) return -DMAX;
    return d;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SMAX) return SMAX;
    if (s < SMIN) return SMIN;
    return s;
  endfunction

  // trunc(num * 2^FRAC_BITS / den), saturated to the sum range
  function automatic longint scaled_div(longint num, longint den);
    logic [127:0] n, d, q;
    n = {64'd0, (num < 0) ? -num : num} << mta_pkg::FRAC_BITS;
    d = {64'd0, (den < 0) ? -den : den};
    q = n / d;
    if (q > SMAX) q = SMAX;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] unit_comp(longint s, int sh, longint unsigned len);
    longint unsigned q;
    q = (((s < 0) ? -s : s) >> sh) << mta_pkg::OUT_FRAC;
    q = q / len;
    if (q > mta_pkg::OUT_ONE) q = mta_pkg::OUT_ONE;
    return (s < 0) ? -16'(q) : 16'(q);
  endfunction

  function automatic tangent_t unit_tangent(int v);
    tangent_t t;
    longint unsigned mx, my, mz, big, len;
    int sh;
    t = '{0, 0, 0, 1'b1};
    mx = (acc_x[v] < 0) ? -acc_x[v] : acc_x[v];
    my = (acc_y[v] < 0) ? -acc_y[v] : acc_y[v];
    mz = (acc_z[v] < 0) ? -acc_z[v] : acc_z[v];
    big = (mx > my) ? mx : my;
    if (mz > big) big = mz;
    if (big == 0) return t;
    sh = 0;
    while ((big >> sh) >= (64'd1 << mta_pkg::MAG_W)) sh++;
    mx >>= sh;
    my >>= sh;
    mz >>= sh;
    len = int_sqrt(mx * mx + my * my + mz * mz);
    if (len == 0) len = 1;
    t.x = unit_comp(acc_x[v], sh, len);
    t.y = unit_comp(acc_y[v], sh, len);
    t.z = unit_comp(acc_z[v], sh, len);
    t.zl = 1'b0;
    return t;
  endfunction

  task automatic add_triangle(int a, int b, int c);
    longint e1x, e1y, e1z, e2x, e2y, e2z, d1u, d1v, d2u, d2v, den, tx, ty, tz;
    int k [3];
    e1x = sat_diff(vx[b], vx[a]); e1y = sat_diff(vy[b], vy[a]); e1z = sat_diff(vz[b], vz[a]);
    e2x = sat_diff(vx[c], vx[a]); e2y = sat_diff(vy[c], vy[a]); e2z = sat_diff(vz[c], vz[a]);
    d1u = sat_diff(vu[b], vu[a]); d1v = sat_diff(vv[b], vv[a]);
    d2u = sat_diff(vu[c], vu[a]); d2v = sat_diff(vv[c], vv[a]);
    den = d1u * d2v - d2u * d1v;
    if (den == 0) return;
    tx = scaled_div(d2v * e1x - d1v * e2x, den);
    ty = scaled_div(d2v * e1y - d1v * e2y, den);
    tz = scaled_div(d2v * e1z - d1v * e2z, den);
    k = '{a, b, c};
    foreach (k[i]) begin
      acc_x[k[i]] = sat_sum(acc_x[k[i]], tx);
      acc_y[k[i]] = sat_sum(acc_y[k[i]], ty);
      acc_z[k[i]] = sat_sum(acc_z[k[i]], tz);
    end
  endtask

  // advance the predictor by one accepted word
  task automatic predict_word(row_t r);
    tangent_t t;
    case (r.fn)
      mta_pkg::OP_WRITE: begin
        vx[r.ia] = r.px; vy[r.ia] = r.py; vz[r.ia] = r.pz;
        vu[r.ia] = r.tu; vv[r.ia] = r.tv;
        acc_x[r.ia] = 0; acc_y[r.ia] = 0; acc_z[r.ia] = 0;
        if (!written[r.ia]) written_q.push_front(r.ia);
        written[r.ia] = 1'b1;
      end
      mta_pkg::OP_TRI: add_triangle(r.ia, r.ib, r.ic);
      mta_pkg::OP_READ: begin
        if (r.typed) t = '{r.ex, r.ey, r.ez, r.ezl};
        else t = unit_tangent(r.ia);
        tangent_q = {tangent_q, t};
      end
      default: ;
    endcase
  endtask

  function automatic int pause_len();
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic send(row_t r);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i = r.fn;
    vertex_index_i = IW'(r.ia); second_index_i = IW'(r.ib); third_index_i = IW'(r.ic);
    pos_x_i = r.px; pos_y_i = r.py; pos_z_i = r.pz; tex_u_i = r.tu; tex_v_i = r.tv;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(r);
    @(negedge clk_i);
  endtask

  function automatic row_t mk(logic [1:0] fn, int a, int b, int c, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] pz,
                              logic signed [31:0] tu, logic signed [31:0] tv);
    row_t r;
    r = '{fn, a, b, c, px, py, pz, tu, tv, 1'b0, 0, 0, 0, 1'b0};
    return r;
  endfunction

  function automatic row_t wr(int a, logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz, logic signed [31:0] tu,
                              logic signed [31:0] tv);
    return mk(mta_pkg::OP_WRITE, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
              px, py, pz, tu, tv);
  endfunction

  function automatic row_t tri3(int a, int b, int c);
    return mk(mta_pkg::OP_TRI, a, b, c, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic row_t rd(int a);
    return mk(mta_pkg::OP_READ, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic row_t rd_is(int a, logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z, logic zl);
    row_t r;
    r = rd(a);
    r.typed = 1'b1;
    r.ex = x; r.ey = y; r.ez = z; r.ezl = zl;
    return r;
  endfunction

  function automatic logic signed [31:0] coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return 32'($urandom_range(0, 64)) - 32 <<< 16;
      default: return 32'($urandom_range(0, 1 << 22)) - (1 << 21);
    endcase
  endfunction

  function automatic int pick_index();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 47);
  endfunction

  function automatic int pick_written();
    return written_q[$urandom_range(0, written_q.size() - 1)];
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // compare every returned word with the oldest predicted tangent
  always @(posedge clk_i) begin
    tangent_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tangent_q.size() == 0) begin
        $display("%0t: unexpected tangent %0d %0d %0d zl %0b", $time,
                 tangent_x_o, tangent_y_o, tangent_z_o, zero_length_o);
        errors++;
      end else begin
        e = tangent_q.pop_front();
        if (tangent_x_o !== e.x) begin
          $display("%0t: tangent_x expected %0d got %0d", $time, e.x, tangent_x_o);
          errors++;
        end
        if (tangent_y_o !== e.y) begin
          $display("%0t: tangent_y expected %0d got %0d", $time, e.y, tangent_y_o);
          errors++;
        end
        if (tangent_z_o !== e.z) begin
          $display("%0t: tangent_z expected %0d got %0d", $time, e.z, tangent_z_o);
          errors++;
        end
        if (zero_length_o !== e.zl) begin
          $display("%0t: zero_length expected %0b got %0b", $time, e.zl, zero_length_o);
          errors++;
        end
      end
    end
  end

  // result side: random stalls, held off while burst is on
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = pause_len();
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    row_t r;
    int sel;
    foreach (acc_x[i]) begin
      acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
      vx[i] = 0; vy[i] = 0; vz[i] = 0; vu[i] = 0; vv[i] = 0;
      written[i] = 1'b0;
    end

    add_step(rd_is(5, 0, 0, 0, 1'b1));
    add_step(wr(0, 0, 0, 0, 0, 0));
    add_step(wr(1, 32'sh10000, 0, 0, 32'sh10000, 0));
    add_step(wr(2, 0, 32'sh10000, 0, 0, 32'sh10000));
    add_step(tri3(0, 1, 2));
    add_step(rd_is(0, 16'sd32767, 0, 0, 1'b0));
    add_step(rd_is(2, 16'sd32767, 0, 0, 1'b0));
    add_step(wr(0, 0, 0, 0, 0, 0));
    add_step(tri3(0, 0, 1));   // repeated corner, zero determinant
    add_step(rd_is(0, 0, 0, 0, 1'b1));
    add_step(wr(10, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                32'sh80000000, 32'sh80000000));
    add_step(wr(11, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh7fffffff, 32'sh80000000));
    add_step(wr(12, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    add_step(tri3(10, 11, 12));
    add_step(rd(10));
    add_step(rd(12));
    add_step(wr(20, 0, 0, 0, 0, 0));
    add_step(wr(21, 32'sh7fffffff, 32'sh7fffffff, 0, 1, 0));
    add_step(wr(22, 0, 0, 32'sh7fffffff, 0, 1));
    for (int i = 0; i < 3; i++) add_step(tri3(20, 21, 22));  // drive sums to saturation
    add_step(rd(20));
    add_step(wr(1023, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                32'sh7fffffff, 32'sh7fffffff));
    add_step(mk(FN_UNUSED, 1023, 1023, 1023, '1, '1, '1, '1, '1));
    add_step(rd_is(1023, 0, 0, 0, 1'b1));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (steps[i]) send(steps[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 99) < 2) burst = !burst;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        r = wr(pick_index(), coord(), coord(), coord(), coord(), coord());
      end else if (sel < 68) begin
        r = tri3(pick_written(), pick_written(), pick_written());
      end else if (sel < 96) begin
        r = rd(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : pick_written());
      end else begin
        r = mk(FN_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 1023), $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      send(r);
    end
    in_valid_i = 1'b0;

    while (tangent_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
